// ----- rtl/tq_pkg.sv -----
// Shared types, widths and codes of the sorted timer queue.
// No dependencies; used by the interfaces, the top level and the testbench.
package tq_pkg;

  localparam int QueueDepth = 64;
  localparam int TimeW      = 48;
  localparam int IdW        = 32;
  localparam int TagW       = 16;
  localparam int DelayW     = 32;
  localparam int AddrW      = $clog2(QueueDepth);
  localparam int CntW       = $clog2(QueueDepth + 1);

  typedef logic [CntW-1:0]  cnt_t;
  typedef logic [AddrW-1:0] addr_t;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_CANCEL = 2'd1,
    OP_TICK   = 2'd2,
    OP_DRAIN  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_CREATED     = 4'd0,
    ST_NO_KIND     = 4'd1,
    ST_FULL        = 4'd2,
    ST_CANCELLED   = 4'd3,
    ST_NOT_FOUND   = 4'd4,
    ST_FIRED       = 4'd5,
    ST_NONE_DUE    = 4'd6,
    ST_DRAINED     = 4'd7,
    ST_DRAIN_EMPTY = 4'd8
  } status_e;

  typedef struct packed {
    logic [TimeW-1:0] due;
    logic [IdW-1:0]   id;
    logic [TagW-1:0]  tag;
    logic [1:0]       kind;
    logic             grade;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

endpackage

// ----- rtl/tq_in_if.sv -----
// Request channel of the sorted timer queue: valid/ready plus one request item.
// Depends on tq_pkg for field widths.
interface tq_in_if;
  import tq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               op;
  logic [TimeW-1:0]         now_ticks;
  logic signed [DelayW-1:0] delay_ticks;
  logic [TagW-1:0]          action_tag;
  logic [1:0]               action_kind;
  logic                     report_grade;
  logic [IdW-1:0]           target_id;

  modport source (output valid, op, now_ticks, delay_ticks, action_tag, action_kind,
                  report_grade, target_id, input ready);
  modport sink   (input valid, op, now_ticks, delay_ticks, action_tag, action_kind,
                  report_grade, target_id, output ready);
endinterface

// ----- rtl/tq_out_if.sv -----
// Result channel of the sorted timer queue: valid/ready plus one result item.
// Depends on tq_pkg for field widths.
interface tq_out_if;
  import tq_pkg::*;
  logic             valid;
  logic             ready;
  logic [3:0]       status;
  logic [IdW-1:0]   entry_id;
  logic [TimeW-1:0] due_ticks;
  logic [TagW-1:0]  out_tag;
  logic [1:0]       out_kind;
  logic             rpt_grade;
  logic [CntW-1:0]  pending_count;
  logic             last;

  modport source (output valid, status, entry_id, due_ticks, out_tag, out_kind, rpt_grade,
                  pending_count, last, input ready);
  modport sink   (input valid, status, entry_id, due_ticks, out_tag, out_kind, rpt_grade,
                  pending_count, last, output ready);
endinterface

// ----- rtl/tq_ram.sv -----
// Simple dual-port synchronous RAM, one write and one read port, registered read.
// Read data holds when no read is issued. No dependencies.
module tq_ram #(
  parameter int Depth = 64,
  parameter int Width = 99
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- rtl/sorted_timer_queue_top.sv -----
// Sorted timer queue: top level with the sequencer that walks the entry RAM.
// Depends on tq_pkg, tq_in_if, tq_out_if and tq_ram.
//
// Usage: requests arrive on req_i (valid/ready), results leave on rsp_o
// (valid/ready); a transfer happens on a clock edge with valid and ready high.
// One request is handled at a time; req_i.ready is high only while idle.
// Every request yields at least one result; the final one has last set.
// Entries live in a circular RAM kept in due-time order with a head pointer.
// Create walks from the tail toward the head, one entry per cycle as bound by
// the single RAM read port, moving later entries up by one, then writes
// the new entry into the hole. Cancel scans from the head for the id and
// then closes the gap. Tick and drain pop the head, then give one result
// per cycle while the receiver does not stall. A request on an empty queue
// answers with a single result. Results pass through one output register;
// the sequencer holds while that register is full and the receiver stalls.
// Reset empties the queue and sets the next id to one; the RAM needs no clearing.
module sorted_timer_queue_top (
  input  logic clk_i,
  input  logic rst_ni,
  tq_in_if.sink    req_i,
  tq_out_if.source rsp_o
);
  import tq_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_INS   = 4'd2;
  localparam logic [3:0] S_PUT   = 4'd3;
  localparam logic [3:0] S_CAN   = 4'd4;
  localparam logic [3:0] S_CSH   = 4'd5;
  localparam logic [3:0] S_CFIN  = 4'd6;
  localparam logic [3:0] S_THEAD = 4'd7;
  localparam logic [3:0] S_TNEXT = 4'd8;
  localparam logic [3:0] S_TLAST = 4'd9;

  typedef struct packed {
    status_e          status;
    entry_t           ent;
    cnt_t             pending;
    logic             last;
  } res_t;

  function automatic addr_t phys(addr_t h, cnt_t l);
    logic [AddrW:0] s;
    s = (AddrW+1)'(h) + (AddrW+1)'(l);
    if (s >= (AddrW+1)'(QueueDepth)) begin
      s = s - (AddrW+1)'(QueueDepth);
    end
    return s[AddrW-1:0];
  endfunction

  function automatic res_t mk_res(status_e st, entry_t e, cnt_t p, logic l);
    res_t r;
    r.status  = st;
    r.ent     = e;
    r.pending = p;
    r.last    = l;
    return r;
  endfunction

  logic [3:0]        state_q, state_d;
  cnt_t              occ_q, occ_d;
  addr_t             head_q, head_d;
  cnt_t              l_q, l_d;
  logic [IdW-1:0]    next_id_q, next_id_d;
  entry_t            new_q, new_d;
  entry_t            hold_q, hold_d;
  op_e               op_q;
  logic [TimeW-1:0]  now_q;
  logic [DelayW-1:0] delay_q;
  logic [TagW-1:0]   tag_q;
  logic [1:0]        kind_q;
  logic              grade_q;
  logic [IdW-1:0]    target_q;
  logic              ov_q;
  res_t              res_q, res_d;
  logic              out_load;

  logic              we, re;
  addr_t             waddr, raddr;
  entry_t            wdata, rd;
  logic [EntryW-1:0] rdata;

  logic              can_emit, req_xfer, is_tick;
  logic [TimeW:0]    due_sum;
  logic [TimeW-1:0]  due_new;
  logic [IdW-1:0]    id_inc;

  tq_ram #(.Depth(QueueDepth), .Width(EntryW)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign rd       = entry_t'(rdata);
  assign can_emit = !ov_q || rsp_o.ready;
  assign req_xfer = req_i.valid && req_i.ready;
  assign is_tick  = (op_q == OP_TICK);

  // Clamp negative delay to zero, saturate the sum at the top of the time range.
  assign due_sum = {1'b0, now_q}
                 + (TimeW+1)'(delay_q[DelayW-1] ? '0 : delay_q[DelayW-2:0]);
  assign due_new = due_sum[TimeW] ? '1 : due_sum[TimeW-1:0];
  assign id_inc  = next_id_q + IdW'(1);

  always_comb begin
    state_d   = state_q;
    occ_d     = occ_q;
    head_d    = head_q;
    l_d       = l_q;
    next_id_d = next_id_q;
    new_d     = new_q;
    hold_d    = hold_q;
    out_load  = 1'b0;
    res_d     = res_q;
    we        = 1'b0;
    waddr     = phys(head_q, l_q);
    wdata     = rd;
    re        = 1'b0;
    raddr     = phys(head_q, '0);

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        case (op_q)
          OP_CREATE: begin
            if (kind_q == 2'd0 || occ_q == CntW'(QueueDepth)) begin
              if (can_emit) begin
                out_load = 1'b1;
                res_d    = mk_res((kind_q == 2'd0) ? ST_NO_KIND : ST_FULL, '0, occ_q, 1'b1);
                state_d  = S_IDLE;
              end
            end else begin
              new_d     = '{due: due_new, id: next_id_q, tag: tag_q, kind: kind_q,
                            grade: grade_q};
              next_id_d = (id_inc == '0) ? IdW'(1) : id_inc;
              l_d       = occ_q;
              if (occ_q == '0) begin
                state_d = S_PUT;
              end else begin
                re      = 1'b1;
                raddr   = phys(head_q, occ_q - cnt_t'(1));
                state_d = S_INS;
              end
            end
          end
          OP_CANCEL: begin
            if (occ_q == '0) begin
              if (can_emit) begin
                out_load = 1'b1;
                res_d    = mk_res(ST_NOT_FOUND, '0, occ_q, 1'b1);
                state_d  = S_IDLE;
              end
            end else begin
              re      = 1'b1;
              l_d     = '0;
              state_d = S_CAN;
            end
          end
          default: begin
            if (occ_q == '0) begin
              if (can_emit) begin
                out_load = 1'b1;
                res_d    = mk_res(is_tick ? ST_NONE_DUE : ST_DRAIN_EMPTY, '0, occ_q, 1'b1);
                state_d  = S_IDLE;
              end
            end else begin
              re      = 1'b1;
              state_d = S_THEAD;
            end
          end
        endcase
      end
      S_INS: begin
        // rd is the entry just below the hole; move it up while it is due later
        if (rd.due > new_q.due) begin
          we  = 1'b1;
          l_d = l_q - cnt_t'(1);
          if (l_q > cnt_t'(1)) begin
            re    = 1'b1;
            raddr = phys(head_q, l_q - cnt_t'(2));
          end else begin
            state_d = S_PUT;
          end
        end else begin
          state_d = S_PUT;
        end
      end
      S_PUT: begin
        if (can_emit) begin
          we       = 1'b1;
          wdata    = new_q;
          occ_d    = occ_q + cnt_t'(1);
          out_load = 1'b1;
          res_d    = mk_res(ST_CREATED, new_q, occ_q + cnt_t'(1), 1'b1);
          state_d  = S_IDLE;
        end
      end
      S_CAN: begin
        if (rd.id == target_q) begin
          hold_d = rd;
          if (l_q + cnt_t'(1) < occ_q) begin
            re      = 1'b1;
            raddr   = phys(head_q, l_q + cnt_t'(1));
            state_d = S_CSH;
          end else begin
            state_d = S_CFIN;
          end
        end else if (l_q + cnt_t'(1) < occ_q) begin
          re    = 1'b1;
          raddr = phys(head_q, l_q + cnt_t'(1));
          l_d   = l_q + cnt_t'(1);
        end else if (can_emit) begin
          out_load = 1'b1;
          res_d    = mk_res(ST_NOT_FOUND, '0, occ_q, 1'b1);
          state_d  = S_IDLE;
        end
      end
      S_CSH: begin
        // close the gap: rd is the entry after the hole
        we  = 1'b1;
        l_d = l_q + cnt_t'(1);
        if (l_q + cnt_t'(2) < occ_q) begin
          re    = 1'b1;
          raddr = phys(head_q, l_q + cnt_t'(2));
        end else begin
          state_d = S_CFIN;
        end
      end
      S_CFIN: begin
        if (can_emit) begin
          occ_d    = occ_q - cnt_t'(1);
          out_load = 1'b1;
          res_d    = mk_res(ST_CANCELLED, hold_q, occ_q - cnt_t'(1), 1'b1);
          state_d  = S_IDLE;
        end
      end
      S_THEAD: begin
        if (is_tick && rd.due > now_q) begin
          if (can_emit) begin
            out_load = 1'b1;
            res_d    = mk_res(ST_NONE_DUE, '0, occ_q, 1'b1);
            state_d  = S_IDLE;
          end
        end else begin
          hold_d = rd;
          head_d = phys(head_q, cnt_t'(1));
          occ_d  = occ_q - cnt_t'(1);
          if (occ_q > cnt_t'(1)) begin
            re      = 1'b1;
            raddr   = phys(head_q, cnt_t'(1));
            state_d = S_TNEXT;
          end else begin
            state_d = S_TLAST;
          end
        end
      end
      S_TNEXT: begin
        // hold is popped already; rd is the new head and decides last
        if (can_emit) begin
          out_load = 1'b1;
          res_d    = mk_res(is_tick ? ST_FIRED : ST_DRAINED, hold_q, occ_q,
                            is_tick && rd.due > now_q);
          if (is_tick && rd.due > now_q) begin
            state_d = S_IDLE;
          end else begin
            hold_d = rd;
            head_d = phys(head_q, cnt_t'(1));
            occ_d  = occ_q - cnt_t'(1);
            if (occ_q > cnt_t'(1)) begin
              re    = 1'b1;
              raddr = phys(head_q, cnt_t'(1));
            end else begin
              state_d = S_TLAST;
            end
          end
        end
      end
      S_TLAST: begin
        if (can_emit) begin
          out_load = 1'b1;
          res_d    = mk_res(is_tick ? ST_FIRED : ST_DRAINED, hold_q, occ_q, 1'b1);
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      occ_q     <= '0;
      head_q    <= '0;
      next_id_q <= IdW'(1);
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      occ_q     <= occ_d;
      head_q    <= head_d;
      next_id_q <= next_id_d;
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (rsp_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    l_q    <= l_d;
    new_q  <= new_d;
    hold_q <= hold_d;
    res_q  <= res_d;
    if (req_xfer) begin
      op_q     <= op_e'(req_i.op);
      now_q    <= req_i.now_ticks;
      delay_q  <= req_i.delay_ticks;
      tag_q    <= req_i.action_tag;
      kind_q   <= req_i.action_kind;
      grade_q  <= req_i.report_grade;
      target_q <= req_i.target_id;
    end
  end

  assign req_i.ready         = (state_q == S_IDLE);
  assign rsp_o.valid         = ov_q;
  assign rsp_o.status        = res_q.status;
  assign rsp_o.entry_id      = res_q.ent.id;
  assign rsp_o.due_ticks     = res_q.ent.due;
  assign rsp_o.out_tag       = res_q.ent.tag;
  assign rsp_o.out_kind      = res_q.ent.kind;
  assign rsp_o.rpt_grade     = res_q.ent.grade;
  assign rsp_o.pending_count = res_q.pending;
  assign rsp_o.last          = res_q.last;

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CntW'(QueueDepth))
    else $error("occupancy above queue depth");

  a_id_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_id_q != '0)
    else $error("next id is zero");

  a_put_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUT && can_emit) |=> occ_q == $past(occ_q) + cnt_t'(1))
    else $error("insert did not grow the queue");

  a_created_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status == ST_CREATED) |-> rsp_o.entry_id != '0)
    else $error("created entry carries id zero");

endmodule

// ----- tb/sv/sorted_timer_queue_top_tb.sv -----
// Self-checking testbench for the sorted timer queue: random and directed requests,
// a behavioral queue model predicts every result. Depends on tq_pkg, tq_in_if, tq_out_if.
module sorted_timer_queue_top_tb;
  import tq_pkg::*;

  typedef struct {
    op_e              op;
    logic [TimeW-1:0] now;
    logic [DelayW-1:0] delay;
    logic [TagW-1:0]  tag;
    logic [1:0]       kind;
    logic             grade;
    logic [IdW-1:0]   target;
  } req_t;

  typedef struct {
    status_e          status;
    logic [IdW-1:0]   id;
    logic [TimeW-1:0] due;
    logic [TagW-1:0]  tag;
    logic [1:0]       kind;
    logic             grade;
    logic [CntW-1:0]  pending;
    logic             last;
  } rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tq_in_if  req_if ();
  tq_out_if rsp_if ();

  sorted_timer_queue_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #4 clk_i = ~clk_i;

  req_t   pending_reqs[$];
  rsp_t   expected_rsps[$];
  entry_t timer_list[$];
  logic [IdW-1:0]   next_timer_id = 1;
  int errors = 0;
  int n_sent = 0;
  int n_results = 0;
  int hist[9];

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void add_req(req_t q);
    pending_reqs.insert(pending_reqs.size(), q);
  endfunction

  function automatic void push_rsp(status_e st, entry_t e, logic lst);
    rsp_t r;
    r.status = st; r.id = e.id; r.due = e.due; r.tag = e.tag;
    r.kind = e.kind; r.grade = e.grade; r.pending = CntW'(timer_list.size()); r.last = lst;
    expected_rsps.insert(expected_rsps.size(), r);
  endfunction

  // Predict the results of one accepted request and update the shadow queue.
  function automatic void predict_queue(req_t q);
    entry_t e, nil;
    logic [TimeW:0] sum;
    logic [TimeW-1:0] d;
    int pos;
    bit hit;
    nil = '0;
    hit = 0;
    case (q.op)
      OP_CREATE: begin
        if (q.kind == 2'd0) push_rsp(ST_NO_KIND, nil, 1'b1);
        else if (timer_list.size() >= QueueDepth) push_rsp(ST_FULL, nil, 1'b1);
        else begin
          d = q.delay[DelayW-1] ? '0 : TimeW'(q.delay);
          sum = {1'b0, q.now} + {1'b0, d};
          e.due = sum[TimeW] ? {TimeW{1'b1}} : sum[TimeW-1:0];
          e.id = next_timer_id;
          e.tag = q.tag; e.kind = q.kind; e.grade = q.grade;
          next_timer_id = next_timer_id + IdW'(1);
          if (next_timer_id == 0) next_timer_id = 1;
          pos = 0;
          while (pos < timer_list.size() && timer_list[pos].due <= e.due) pos++;
          timer_list.insert(pos, e);
          push_rsp(ST_CREATED, e, 1'b1);
        end
      end
      OP_CANCEL: begin
        for (int i = 0; i < timer_list.size(); i++) begin
          if (!hit && timer_list[i].id == q.target) begin
            e = timer_list[i];
            timer_list.delete(i);
            push_rsp(ST_CANCELLED, e, 1'b1);
            hit = 1;
          end
        end
        if (!hit) push_rsp(ST_NOT_FOUND, nil, 1'b1);
      end
      OP_TICK: begin
        if (timer_list.size() == 0 || timer_list[0].due > q.now)
          push_rsp(ST_NONE_DUE, nil, 1'b1);
        else
          while (timer_list.size() > 0 && timer_list[0].due <= q.now) begin
            e = timer_list.pop_front();
            push_rsp(ST_FIRED, e, timer_list.size() == 0 || timer_list[0].due > q.now);
          end
      end
      default: begin
        if (timer_list.size() == 0) push_rsp(ST_DRAIN_EMPTY, nil, 1'b1);
        else
          while (timer_list.size() > 0) begin
            e = timer_list.pop_front();
            push_rsp(ST_DRAINED, e, timer_list.size() == 0);
          end
      end
    endcase
  endfunction

  function automatic req_t mk(op_e op, logic [TimeW-1:0] now, logic [DelayW-1:0] dl,
                              logic [1:0] kind, logic [IdW-1:0] tgt);
    req_t q;
    q.op = op; q.now = now; q.delay = dl; q.kind = kind; q.target = tgt;
    q.tag = TagW'($urandom()); q.grade = 1'($urandom_range(0, 1));
    return q;
  endfunction

  function automatic logic [TimeW-1:0] rand_time();
    return TimeW'({$urandom(), $urandom()});
  endfunction

  // Driver: present queued requests with random gaps.
  int drv_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    req_t q;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.op <= OP_CREATE;
      req_if.now_ticks <= '0;
      req_if.delay_ticks <= '0;
      req_if.action_tag <= '0;
      req_if.action_kind <= '0;
      req_if.report_grade <= 1'b0;
      req_if.target_id <= '0;
      drv_gap <= 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        predict_queue(pending_reqs.pop_front());
        n_sent++;
      end
      if (req_if.valid && !req_if.ready) begin
        // hold until transfer
      end else if (drv_gap > 0) begin
        req_if.valid <= 1'b0;
        drv_gap <= drv_gap - 1;
      end else if (pending_reqs.size() > 0) begin
        q = pending_reqs[0];
        req_if.valid <= 1'b1;
        req_if.op <= q.op;
        req_if.now_ticks <= q.now;
        req_if.delay_ticks <= q.delay;
        req_if.action_tag <= q.tag;
        req_if.action_kind <= q.kind;
        req_if.report_grade <= q.grade;
        req_if.target_id <= q.target;
        drv_gap <= gap_len();
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Monitor: random backpressure and field-by-field comparison.
  int stall = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t exp_r;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      stall <= 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        n_results++;
        if (rsp_if.status < 9) hist[rsp_if.status]++;
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected result status=%0d id=%0d", $time, rsp_if.status,
                   rsp_if.entry_id);
          errors++;
        end else begin
          exp_r = expected_rsps.pop_front();
          if (rsp_if.status !== exp_r.status || rsp_if.entry_id !== exp_r.id ||
              rsp_if.due_ticks !== exp_r.due || rsp_if.out_tag !== exp_r.tag ||
              rsp_if.out_kind !== exp_r.kind || rsp_if.rpt_grade !== exp_r.grade ||
              rsp_if.pending_count !== exp_r.pending || rsp_if.last !== exp_r.last) begin
            $display("%0t: mismatch expected st=%0d id=%0d due=%0h tag=%0h k=%0d g=%0d n=%0d l=%0d",
                     $time, exp_r.status, exp_r.id, exp_r.due, exp_r.tag, exp_r.kind,
                     exp_r.grade, exp_r.pending, exp_r.last);
            $display("%0t:          actual st=%0d id=%0d due=%0h tag=%0h k=%0d g=%0d n=%0d l=%0d",
                     $time, rsp_if.status, rsp_if.entry_id, rsp_if.due_ticks, rsp_if.out_tag,
                     rsp_if.out_kind, rsp_if.rpt_grade, rsp_if.pending_count, rsp_if.last);
            errors++;
          end
        end
      end
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        stall <= stall - 1;
      end else begin
        rsp_if.ready <= 1'b1;
        stall <= ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      end
    end
  end

  initial begin
    logic [TimeW-1:0] t;
    int r;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty-queue misses, refusals, extremes, saturation, equal dues.
    add_req(mk(OP_TICK, '0, '0, 2'd1, '0));
    add_req(mk(OP_DRAIN, '0, '0, 2'd1, '0));
    add_req(mk(OP_CANCEL, '0, '0, 2'd1, '0));
    add_req(mk(OP_CREATE, 48'd100, 32'd5, 2'd0, '0));
    add_req(mk(OP_CREATE, 48'd100, 32'h8000_0000, 2'd1, '0));
    add_req(mk(OP_CREATE, {TimeW{1'b1}}, 32'h7fff_ffff, 2'd2, '0));
    add_req(mk(OP_CREATE, 48'd90, 32'd10, 2'd3, '0));
    add_req(mk(OP_CREATE, 48'd100, 32'hffff_ffff, 2'd1, '0));
    add_req(mk(OP_CREATE, 48'd0, 32'd50, 2'd2, {IdW{1'b1}}));
    add_req(mk(OP_CANCEL, '0, '0, 2'd1, 32'd3));
    add_req(mk(OP_CANCEL, '0, '0, 2'd1, 32'd3));
    add_req(mk(OP_CANCEL, '0, '0, 2'd1, {IdW{1'b1}}));
    add_req(mk(OP_TICK, 48'd99, '0, 2'd1, '0));
    add_req(mk(OP_TICK, 48'd100, '0, 2'd1, '0));
    add_req(mk(OP_DRAIN, '0, '0, 2'd1, '0));
    // Fill to capacity, then one refused create, then a kind-zero create while full.
    for (int i = 0; i < QueueDepth; i++)
      add_req(mk(OP_CREATE, 48'd1000, $urandom_range(0, 20), 2'd1, '0));
    add_req(mk(OP_CREATE, 48'd1000, 32'd1, 2'd2, '0));
    add_req(mk(OP_CREATE, 48'd1000, 32'd1, 2'd0, '0));
    add_req(mk(OP_TICK, 48'd1010, '0, 2'd1, '0));
    add_req(mk(OP_DRAIN, '0, '0, 2'd1, '0));

    // Random: mostly creates around a moving clock, with cancels of recent or random ids, ticks and occasional drains.
    t = 48'd5000;
    for (int i = 0; i < 76; i++) begin
      r = $urandom_range(0, 99);
      t = t + TimeW'($urandom_range(0, 30));
      if (r < 50)
        add_req(mk(OP_CREATE, ($urandom_range(0, 15) == 0) ? rand_time() : t,
          ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 100),
          ($urandom_range(0, 19) == 0) ? 2'd0 : 2'($urandom_range(1, 3)), $urandom()));
      else if (r < 70)
        add_req(mk(OP_CANCEL, rand_time(), $urandom(), 2'($urandom()),
          ($urandom_range(0, 4) == 0) ? $urandom() : 32'(n_sent + $urandom_range(0, 60))));
      else if (r < 95)
        add_req(mk(OP_TICK, ($urandom_range(0, 19) == 0) ? rand_time() : t,
                   $urandom(), 2'($urandom()), $urandom()));
      else
        add_req(mk(OP_DRAIN, rand_time(), $urandom(), 2'($urandom()), $urandom()));
    end

    wait (pending_reqs.size() == 0);
    @(posedge clk_i);
    wait (expected_rsps.size() == 0);
    repeat (QueueDepth + 10) @(posedge clk_i);
    $display("Sent %0d requests, checked %0d results.", n_sent, n_results);
    $display("By status: created %0d nokind %0d full %0d cancel %0d miss %0d fired %0d drained %0d",
             hist[0], hist[1], hist[2], hist[3], hist[4], hist[5], hist[7]);
    if (errors == 0 && expected_rsps.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #20000000;
    $display("Timeout with %0d results outstanding", expected_rsps.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
